// ----- rtl/lrc_pkg.sv -----
// Shared types and constants of the long run collapser.
package lrc_pkg;

	// Sample width and the longest run that can ever be replayed
	localparam int DATA_WIDTH = 32;
	localparam int MAX_LIMIT  = 32;

	// Width of the run_limit register field
	localparam int LIM_W      = 6;

	// Run counter saturates at MAX_LIMIT + 1
	localparam int CNT_W      = $clog2(MAX_LIMIT + 2);
	localparam int SAT_LEN    = MAX_LIMIT + 1;

	// Register map: word index of each register
	localparam int ADDR_W     = 3;
	localparam logic [ADDR_W-3:0] REG_RUN_LIMIT = '0;

	// Reset value of run_limit
	localparam logic [LIM_W-1:0] RUN_LIMIT_RST = LIM_W'(1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FLUSH_A,
		ST_FLUSH_B
	} lrc_state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic accept;
		logic step;
		logic sel_b;
	} lrc_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic fa_en_next;
		logic fb_en_next;
		logic fb_en;
		logic out_free;
		logic run_done;
	} lrc_status_t;

endpackage

// ----- rtl/lrc_cfg.sv -----
// APB register block holding run_limit and its clamped form.
module lrc_cfg
	import lrc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output logic [CNT_W-1:0]  limit_eff
);

	logic [LIM_W-1:0] run_limit_q;
	logic             sel_limit;

	assign pready    = 1'b1;
	assign sel_limit = (paddr[ADDR_W-1:2] == REG_RUN_LIMIT);

	// Write run_limit on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_limit_q <= RUN_LIMIT_RST;
		end else if (psel && penable && pwrite && pready && sel_limit) begin
			run_limit_q <= pwdata[LIM_W-1:0];
		end
	end

	// Read back the register, zero elsewhere
	assign prdata = sel_limit ? {{(32-LIM_W){1'b0}}, run_limit_q} : 32'd0;

	// Clamp the limit to the longest replayable run
	always_comb begin
		if (run_limit_q > LIM_W'(MAX_LIMIT)) begin
			limit_eff = CNT_W'(MAX_LIMIT);
		end else begin
			limit_eff = CNT_W'(run_limit_q);
		end
	end

endmodule

// ----- rtl/lrc_datapath.sv -----
// Run tracking, flush buffers, replay counter and output register.
module lrc_datapath
	import lrc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  lrc_cmd_t              cmd,
	output lrc_status_t           status,
	input  logic [DATA_WIDTH-1:0] in_value,
	input  logic                  in_eos,
	input  logic [CNT_W-1:0]      limit_eff,
	input  logic                  out_ready,
	output logic                  out_valid,
	output logic [DATA_WIDTH-1:0] out_value,
	output logic [1:0]            out_user,
	output logic                  out_last
);

	// Pending run
	logic [DATA_WIDTH-1:0] run_value_q;
	logic [CNT_W-1:0]      run_length_q;
	logic                  run_open_q;

	// Flush buffers: A is the run ended by a new sample, B the final run
	logic [DATA_WIDTH-1:0] fa_value_q, fb_value_q;
	logic [CNT_W-1:0]      fa_len_q, fb_len_q;
	logic                  fb_en_q, eos_q;
	logic [CNT_W-1:0]      emit_q;

	// Output register
	logic                  out_valid_q;
	logic [DATA_WIDTH-1:0] out_value_q;
	logic [1:0]            out_user_q;
	logic                  out_last_q;

	logic                  match;
	logic [CNT_W-1:0]      len_inc;
	logic [DATA_WIDTH-1:0] cur_val;
	logic [CNT_W-1:0]      cur_len;
	logic                  collapse, run_done, last_res;

	// Compare the new sample with the pending run
	assign match   = run_open_q && (in_value == run_value_q);
	assign len_inc = (run_length_q < CNT_W'(SAT_LEN)) ? run_length_q + CNT_W'(1)
	                                                  : run_length_q;

	// Select the run being replayed
	assign cur_val  = cmd.sel_b ? fb_value_q : fa_value_q;
	assign cur_len  = cmd.sel_b ? fb_len_q : fa_len_q;
	assign collapse = cur_len > limit_eff;
	assign run_done = collapse || (emit_q == cur_len - CNT_W'(1));
	assign last_res = run_done && (cmd.sel_b || !fb_en_q);

	assign status.fa_en_next = run_open_q && !match;
	assign status.fb_en_next = in_eos;
	assign status.fb_en      = fb_en_q;
	assign status.out_free   = !out_valid_q || out_ready;
	assign status.run_done   = run_done;

	// Update the pending run on each accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_value_q  <= '0;
			run_length_q <= '0;
			run_open_q   <= 1'b0;
		end else if (cmd.accept) begin
			if (in_eos) begin
				run_value_q  <= '0;
				run_length_q <= '0;
				run_open_q   <= 1'b0;
			end else if (match) begin
				run_length_q <= len_inc;
			end else begin
				run_value_q  <= in_value;
				run_length_q <= CNT_W'(1);
				run_open_q   <= 1'b1;
			end
		end
	end

	// Capture the runs to flush
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			fa_value_q <= run_value_q;
			fa_len_q   <= run_length_q;
			fb_value_q <= in_value;
			fb_len_q   <= match ? len_inc : CNT_W'(1);
			eos_q      <= in_eos;
		end
	end

	// Flush control flag and replay counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fb_en_q <= 1'b0;
			emit_q  <= '0;
		end else if (cmd.accept) begin
			fb_en_q <= in_eos;
			emit_q  <= '0;
		end else if (cmd.step) begin
			emit_q  <= run_done ? '0 : emit_q + CNT_W'(1);
		end
	end

	// Output valid: set on a step, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.step) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (cmd.step) begin
			out_value_q <= collapse ? '0 : cur_val;
			out_user_q  <= {last_res, collapse};
			out_last_q  <= last_res && eos_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_value = out_value_q;
	assign out_user  = out_user_q;
	assign out_last  = out_last_q;

endmodule

// ----- rtl/lrc_ctrl.sv -----
// Controller state machine sequencing accept and run flushes.
module lrc_ctrl
	import lrc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  lrc_status_t status,
	output lrc_cmd_t    cmd
);

	lrc_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (status.fa_en_next) begin
						state_d = ST_FLUSH_A;
					end else if (status.fb_en_next) begin
						state_d = ST_FLUSH_B;
					end
				end
			end
			ST_FLUSH_A: begin
				if (status.out_free && status.run_done) begin
					state_d = status.fb_en ? ST_FLUSH_B : ST_IDLE;
				end
			end
			ST_FLUSH_B: begin
				if (status.out_free && status.run_done) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		in_ready   = 1'b0;
		cmd.accept = 1'b0;
		cmd.step   = 1'b0;
		cmd.sel_b  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			ST_FLUSH_A: begin
				cmd.step   = status.out_free;
			end
			ST_FLUSH_B: begin
				cmd.step   = status.out_free;
				cmd.sel_b  = 1'b1;
			end
			default: begin
				in_ready   = 1'b0;
			end
		endcase
	end

endmodule

// ----- rtl/long_run_collapser.sv -----
// Long run collapser: each input transaction is first accepted in the idle state,
// and then its results leave at one per cycle from a single output register
// fed by the replay counter, while the output is not stalled. A run no
// longer than run_limit (clamped to 32) is replayed element by element; a
// longer run gives one zero with the collapse flag set. A new transaction is
// taken while the last result still waits in the output register.
module long_run_collapser
	import lrc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// Input stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [31:0]           s_tdata,  // [31:0] sample_value
	input  logic                  s_tlast,  // end_of_sequence
	// Output stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [31:0]           m_tdata,  // [31:0] out_value
	output logic [1:0]            m_tuser,  // [0] collapse_marker, [1] last_of_burst
	output logic                  m_tlast,  // sequence_done
	// Configuration
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [ADDR_W-1:0]     paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	lrc_cmd_t         cmd;
	lrc_status_t      status;
	logic [CNT_W-1:0] limit_eff;

	lrc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.limit_eff (limit_eff)
	);

	lrc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	lrc_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_value  (s_tdata),
		.in_eos    (s_tlast),
		.limit_eff (limit_eff),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_value (m_tdata),
		.out_user  (m_tuser),
		.out_last  (m_tlast)
	);

endmodule

// ----- rtl/lrc_checker.sv -----
// Port-level checker for the long run collapser and its bind.
module lrc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [1:0]  m_tuser,
	input logic        m_tlast
);

	// While flushing with the output free, a result is loaded in the next cycle
	a_flush_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(!s_tready && (!m_tvalid || m_tready)) |=> m_tvalid)
		else $error("flush stalled with a free output");

	// Collapsed run shows as zero
	a_collapse_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (m_tdata == 32'd0))
		else $error("collapse marker on non-zero data");

	// End of sequence only on the final result of a transaction
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> m_tuser[1])
		else $error("sequence_done without last_of_burst");

	// Stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("stalled result changed");

endmodule

bind long_run_collapser lrc_checker u_lrc_checker (.*);

// ----- verif/testbench.sv -----
// Self-checking testbench for the long run collapser.
module testbench;
	import lrc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int FLUSH_WAIT     = 2 * (MAX_LIMIT + 1) + 10;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int IDLE_PCT       = 8;
	localparam logic [ADDR_W-1:0] RUN_LIMIT_ADDR = {REG_RUN_LIMIT, 2'b00};

	typedef struct packed {
		logic [DATA_WIDTH-1:0] value;
		logic                  eos;
	} sample_t;

	typedef struct packed {
		logic [DATA_WIDTH-1:0] value;
		logic                  collapsed;
		logic                  burst_end;
		logic                  seq_end;
	} result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [31:0]           s_tdata = '0;   // [31:0] sample_value
	logic                  s_tlast = 1'b0; // end_of_sequence
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [31:0]           m_tdata;        // [31:0] out_value
	logic [1:0]            m_tuser;        // [0] collapse_marker, [1] last_of_burst
	logic                  m_tlast;        // sequence_done
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [ADDR_W-1:0]     paddr = '0;
	logic [31:0]           pwdata = '0;
	logic [31:0]           prdata;
	logic                  pready;

	// Predictor state: a mirror of the pending run and the limit register
	logic [DATA_WIDTH-1:0] run_val = '0;
	int unsigned           run_len = 0;
	bit                    run_pending = 1'b0;
	logic [LIM_W-1:0]      limit_reg = RUN_LIMIT_RST;

	sample_t               samples_to_send[$];
	sample_t               in_flight;
	result_t               expected_results[$];
	result_t               replay_buf[$];
	result_t               want_res;
	bit                    gaps_on = 1'b1;
	int                    mismatches = 0;
	int                    quiet_cycles = 0;

	long_run_collapser DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic int eff_limit();
		return (limit_reg > MAX_LIMIT) ? MAX_LIMIT : int'(limit_reg);
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch: %s", msg);
		mismatches++;
	endtask

	// Replay the pending run, or one marked zero if it is too long
	task automatic flush_run();
		if (run_len > eff_limit()) begin
			replay_buf.push_back('{value: '0, collapsed: 1'b1, burst_end: 1'b0, seq_end: 1'b0});
		end else begin
			repeat (run_len)
				replay_buf.push_back('{value: run_val, collapsed: 1'b0, burst_end: 1'b0,
					seq_end: 1'b0});
		end
	endtask

	// Advance the run mirror by one sample and queue the results it causes
	task automatic collapse_step(input sample_t s);
		result_t tail;
		replay_buf.delete();
		if (run_pending && s.value == run_val) begin
			if (run_len < SAT_LEN)
				run_len++;
		end else begin
			if (run_pending)
				flush_run();
			run_val = s.value;
			run_len = 1;
			run_pending = 1'b1;
		end
		if (s.eos) begin
			flush_run();
			run_pending = 1'b0;
			run_len = 0;
			run_val = '0;
		end
		if (replay_buf.size() > 0) begin
			tail = replay_buf[replay_buf.size() - 1];
			tail.burst_end = 1'b1;
			tail.seq_end = s.eos;
			replay_buf[replay_buf.size() - 1] = tail;
		end
		foreach (replay_buf[i])
			expected_results.push_back(replay_buf[i]);
	endtask

	// Input driver: hold each transaction until taken, idle now and then
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				collapse_step(in_flight);
			if (!s_tvalid || s_tready) begin
				if (samples_to_send.size() > 0 && !(gaps_on && $urandom_range(99) < IDLE_PCT)) begin
					in_flight = samples_to_send.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= in_flight.value;
					s_tlast <= in_flight.eos;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Output monitor: stall at random and check each result transaction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= gaps_on ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("result %h with nothing expected", m_tdata));
				end else begin
					want_res = expected_results.pop_front();
					if (m_tdata !== want_res.value || m_tuser[0] !== want_res.collapsed ||
							m_tuser[1] !== want_res.burst_end || m_tlast !== want_res.seq_end)
						report_mismatch($sformatf(
							"got %h mark %b burst %b done %b, wanted %h mark %b burst %b done %b",
							m_tdata, m_tuser[0], m_tuser[1], m_tlast, want_res.value,
							want_res.collapsed, want_res.burst_end, want_res.seq_end));
				end
			end
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(psel && penable && pwrite && pready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Write run_limit through the setup and access phases
	task automatic write_limit(input logic [LIM_W-1:0] lim);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= RUN_LIMIT_ADDR;
		pwdata <= 32'(lim);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		limit_reg = lim;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic add_sample(input logic [DATA_WIDTH-1:0] v, input logic eos);
		samples_to_send.push_back('{value: v, eos: eos});
	endtask

	// Wait until every sample is taken and every result seen, then let the block settle
	task automatic drain();
		while (samples_to_send.size() != 0 || s_tvalid || expected_results.size() != 0)
			@(posedge clk);
		repeat (FLUSH_WAIT) @(posedge clk);
	endtask

	function automatic int pick_run_len();
		int lim;
		int len;
		lim = eff_limit();
		case ($urandom_range(7))
			0, 1, 2: return int'($urandom_range(1, 3));
			3, 4, 5: begin
				len = lim + int'($urandom_range(2)) - 1;
				return (len < 1) ? 1 : len;
			end
			6: return int'($urandom_range(1, MAX_LIMIT + 2));
			default: return 1;
		endcase
	endfunction

	function automatic logic [DATA_WIDTH-1:0] pick_value();
		if ($urandom_range(3) != 0)
			return $urandom();
		case ($urandom_range(4))
			0: return 32'h0000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h8000_0000;
			3: return 32'hFFFF_FFFF;
			default: return 32'h0000_0001;
		endcase
	endfunction

	// Mostly whole sequences of runs, some left open, some loose samples
	task automatic random_phase(input int budget);
		int queued;
		int runs;
		int len;
		int roll;
		logic [DATA_WIDTH-1:0] val;
		logic [DATA_WIDTH-1:0] prev;
		queued = 0;
		while (queued < budget) begin
			roll = $urandom_range(9);
			if (roll == 0) begin
				add_sample($urandom(), 1'($urandom_range(1)));
				queued++;
			end else begin
				runs = $urandom_range(1, 5);
				prev = $urandom();
				for (int r = 0; r < runs && queued < budget; r++) begin
					len = pick_run_len();
					val = pick_value();
					if (val == prev)
						val = $urandom();
					prev = val;
					for (int k = 0; k < len; k++)
						add_sample(val, (roll != 1) && (r == runs - 1) && (k == len - 1));
					queued += len;
				end
			end
		end
	endtask

	initial begin
		logic [LIM_W-1:0] phase_limits[6];
		phase_limits = '{LIM_W'(2), LIM_W'(32), LIM_W'(0), LIM_W'(63), LIM_W'(7),
			LIM_W'($urandom_range(63))};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Reset limit: extremes, a collapsed run, a sample that ends no run
		add_sample(32'h7FFF_FFFF, 1'b1);
		add_sample(32'h8000_0000, 1'b0);
		add_sample(32'h8000_0000, 1'b0);
		add_sample(32'h8000_0000, 1'b1);
		add_sample(32'h0000_0000, 1'b0);
		add_sample(32'hFFFF_FFFF, 1'b1);
		drain();

		// Zero limit: even a lone final sample collapses
		write_limit(LIM_W'(0));
		add_sample(32'h1234_5678, 1'b1);
		add_sample(32'h0000_0001, 1'b0);
		add_sample(32'h0000_0002, 1'b1);
		drain();

		// Limit above range, then lowered while a run is still open
		write_limit(LIM_W'(63));
		add_sample(32'h0000_0005, 1'b0);
		add_sample(32'h0000_0005, 1'b0);
		add_sample(32'h0000_0005, 1'b0);
		drain();
		write_limit(LIM_W'(2));
		add_sample(32'h0000_0006, 1'b1);
		drain();

		// Run exactly at the limit, then one just over it
		write_limit(LIM_W'(3));
		repeat (3) add_sample(32'hFFFF_FFF9, 1'b0);
		repeat (3) add_sample(32'h0000_000A, 1'b0);
		add_sample(32'h0000_000A, 1'b1);
		drain();

		// Random phases over several limits, without gaps at limit 32
		foreach (phase_limits[p]) begin
			write_limit(phase_limits[p]);
			gaps_on = (phase_limits[p] != LIM_W'(32));
			random_phase(20);
			drain();
		end

		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
